// File: rtl/mmv_pkg.sv
`default_nettype none
// ============================================================================
// mmv_pkg: shared constants for the masked mean and variance block
// Result field widths, saturation limits and the packed result layout.
// ============================================================================
package mmv_pkg;

    // Result field widths, fixed by the result format.
    localparam int MEAN_W  = 24;
    localparam int VAR_W   = 39;
    localparam int COUNT_W = 21;

    // Result transaction data width: fields packed from bit 0, padded to bytes.
    localparam int M_TDATA_W = ((MEAN_W + VAR_W + COUNT_W + 7) / 8) * 8;

    // Saturation limits of the result fields.
    localparam logic [MEAN_W-1:0] MEAN_MAX = 24'h7F_FFFF;
    localparam logic [MEAN_W-1:0] MEAN_MIN = 24'h80_0000;
    localparam logic [VAR_W-1:0]  VAR_MAX  = 39'h7F_FFFF_FFFF;

endpackage : mmv_pkg
`default_nettype wire

// File: rtl/masked_mean_variance.sv
`default_nettype none
// ============================================================================
// masked_mean_variance: masked sample mean and sample variance of a frame
// Accumulates masked samples and, at the end of each frame, divides out the
// mean and the unbiased variance with one shared add/subtract unit.
// ============================================================================
// Samples stream in on the slave side, one transaction per clock while the
// block is collecting a frame. tuser is the mask bit: only samples with it set
// enter the exact count, sum and sum of squares, and once the count reaches
// MAX_ITEMS further samples are ignored. The transaction with tlast set ends
// the frame (its own sample is included first). The block then stops taking
// samples and works out the result with a single 75-bit adder/subtractor
// (default sizes) driven by a small sequencer: a restoring divide for the
// mean, three shift-and-add multiplies for count*(count-1), count*sumsq and
// sum^2 (the last one subtracted from the product), and a restoring divide
// for the variance, one bit per clock. Each divide yields QW quotient bits,
// where QW = CNT_W + SQ_W + FRACTION_BITS; the two divides are the longest
// steps. A frame with fewer than two included samples skips the arithmetic.
// In either case the slave side also stays held off while the previous
// result still waits on m_axis_tready, because the last step of the
// sequence hands the new result to the output register.
// The finished result sits in an output register, so a new frame may start
// while the result waits on m_axis_tready. Mean and variance carry
// FRACTION_BITS fraction bits; the mean truncates toward zero, the variance
// rounds down, and both saturate to their fields. With fewer than two
// included samples both are zero and tuser (too_few) is set; the count is
// still reported. All accumulators clear when the result is handed over.
// ============================================================================
module masked_mean_variance
    import mmv_pkg::*;
#(
    parameter int MAX_ITEMS     = 1048576,
    parameter int SAMPLE_BITS   = 16,
    parameter int FRACTION_BITS = 8
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // Sample channel.
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    // tdata: sample (signed, SAMPLE_BITS) from bit 0, zero padded to bytes.
    input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_axis_tdata,
    // tuser: include_req, the mask bit.
    input  wire logic                                 s_axis_tuser,
    // tlast: last sample of the frame.
    input  wire logic                                 s_axis_tlast,
    // Result channel.
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // tdata: mean_value [23:0], variance_value [62:24],
    //        included_count [83:63], zero padding above.
    output logic [M_TDATA_W-1:0]                      m_axis_tdata,
    // tuser: too_few.
    output logic                                      m_axis_tuser
);

    // Internal widths, all following from the parameters.
    localparam int CNT_W   = $clog2(MAX_ITEMS + 1);
    localparam int SUM_W   = SAMPLE_BITS + CNT_W;
    localparam int SQ_W    = 2 * SAMPLE_BITS + CNT_W - 1;
    localparam int A_W     = CNT_W + SQ_W;
    localparam int PROD_W  = ((A_W > 2 * SUM_W) ? A_W : 2 * SUM_W) + 1;
    localparam int DEN_W   = 2 * CNT_W;
    localparam int QW      = A_W + FRACTION_BITS;
    localparam int QX_W    = (QW > 40) ? QW : 40;
    localparam int STEP_W  = $clog2(QW);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_DM,
        S_DEN,
        S_MA,
        S_MB,
        S_DV,
        S_DONE
    } state_t;

    state_t                    state_reg, state_next;
    logic signed [SUM_W-1:0]   sum_reg, sum_next;
    logic [SQ_W-1:0]           sumsq_reg, sumsq_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic [PROD_W-2:0]         mcand_reg, mcand_next;
    logic [SUM_W-1:0]          mplier_reg, mplier_next;
    logic [DEN_W-1:0]          rem_reg, rem_next;
    logic [QW-1:0]             quo_reg, quo_next;
    logic [DEN_W-1:0]          dvsr_reg, dvsr_next;
    logic [STEP_W-1:0]         step_reg, step_next;
    logic [MEAN_W-1:0]         mean_res_reg, mean_res_next;
    logic [VAR_W-1:0]          var_res_reg, var_res_next;
    logic                      m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0]      m_data_reg, m_data_next;
    logic                      m_user_reg, m_user_next;

    logic                      s_accept;
    logic signed [SAMPLE_BITS-1:0] smp;
    logic [SAMPLE_BITS-1:0]    smp_mag;
    logic [2*SAMPLE_BITS-1:0]  smp_sq;
    logic [SUM_W-1:0]          sum_mag;
    logic                      too_few;

    // Shared add/subtract unit.
    logic [PROD_W-1:0]         alu_a, alu_b, alu_res;
    logic                      alu_sub;
    logic [DEN_W:0]            rem_shift;
    logic                      div_ge;
    logic [DEN_W-1:0]          rem_step;
    logic [QW-1:0]             quo_step;
    logic [QX_W-1:0]           quo_ext;
    logic signed [PROD_W-1:0]  prod_step;
    logic [MEAN_W-1:0]         mean_sat;
    logic [VAR_W-1:0]          var_sat;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    // Sample magnitude and its square for the sum of squares.
    assign smp     = signed'(s_axis_tdata[SAMPLE_BITS-1:0]);
    assign smp_mag = smp[SAMPLE_BITS-1] ? SAMPLE_BITS'(-smp) : SAMPLE_BITS'(smp);
    assign smp_sq  = smp_mag * smp_mag;

    assign sum_mag = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign too_few = (cnt_reg < CNT_W'(2));

    // The divide states feed the partial remainder; the multiply states feed
    // the product and the shifted multiplicand.
    assign rem_shift = {rem_reg, quo_reg[QW-1]};

    always_comb begin
        if (state_reg == S_DM || state_reg == S_DV) begin
            alu_a   = PROD_W'(rem_shift);
            alu_b   = PROD_W'(dvsr_reg);
            alu_sub = 1'b1;
        end else begin
            alu_a   = prod_reg;
            alu_b   = {1'b0, mcand_reg};
            alu_sub = (state_reg == S_MB);
        end
        alu_res = alu_a + (alu_sub ? ~alu_b : alu_b) + PROD_W'(alu_sub);
    end

    assign div_ge    = !alu_res[PROD_W-1];
    assign rem_step  = div_ge ? alu_res[DEN_W-1:0] : rem_shift[DEN_W-1:0];
    assign quo_step  = {quo_reg[QW-2:0], div_ge};
    assign quo_ext   = QX_W'(quo_step);
    assign prod_step = mplier_reg[0] ? signed'(alu_res) : prod_reg;

    // Saturation of the final quotients.
    always_comb begin
        if (sum_reg[SUM_W-1]) begin
            mean_sat = (quo_ext > QX_W'(MEAN_MIN)) ? MEAN_MIN
                                                   : MEAN_W'(-quo_ext[MEAN_W-1:0]);
        end else begin
            mean_sat = (quo_ext > QX_W'(MEAN_MAX)) ? MEAN_MAX : quo_ext[MEAN_W-1:0];
        end
        var_sat = (quo_ext > QX_W'(VAR_MAX)) ? VAR_MAX : quo_ext[VAR_W-1:0];
    end

    // Sequencer.
    always_comb begin
        state_next    = state_reg;
        sum_next      = sum_reg;
        sumsq_next    = sumsq_reg;
        cnt_next      = cnt_reg;
        prod_next     = prod_reg;
        mcand_next    = mcand_reg;
        mplier_next   = mplier_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        dvsr_next     = dvsr_reg;
        step_next     = step_reg;
        mean_res_next = mean_res_reg;
        var_res_next  = var_res_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        m_user_next   = m_user_reg;

        if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    if (s_axis_tuser && (cnt_reg < CNT_W'(MAX_ITEMS))) begin
                        sum_next   = sum_reg + SUM_W'(smp);
                        sumsq_next = sumsq_reg + SQ_W'(smp_sq);
                        cnt_next   = cnt_reg + CNT_W'(1);
                    end
                    if (s_axis_tlast) begin
                        state_next = S_START;
                    end
                end
            end
            S_START: begin
                if (too_few) begin
                    mean_res_next = '0;
                    var_res_next  = '0;
                    state_next    = S_DONE;
                end else begin
                    rem_next   = '0;
                    quo_next   = QW'(sum_mag) << FRACTION_BITS;
                    dvsr_next  = DEN_W'(cnt_reg);
                    step_next  = STEP_W'(QW - 1);
                    state_next = S_DM;
                end
            end
            S_DM: begin
                rem_next  = rem_step;
                quo_next  = quo_step;
                step_next = step_reg - STEP_W'(1);
                if (step_reg == '0) begin
                    mean_res_next = mean_sat;
                    prod_next     = '0;
                    mcand_next    = (PROD_W - 1)'(cnt_reg);
                    mplier_next   = SUM_W'(cnt_reg - CNT_W'(1));
                    step_next     = STEP_W'(CNT_W - 1);
                    state_next    = S_DEN;
                end
            end
            S_DEN: begin
                prod_next   = prod_step;
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                step_next   = step_reg - STEP_W'(1);
                if (step_reg == '0) begin
                    dvsr_next   = prod_step[DEN_W-1:0];
                    prod_next   = '0;
                    mcand_next  = (PROD_W - 1)'(sumsq_reg);
                    mplier_next = SUM_W'(cnt_reg);
                    step_next   = STEP_W'(CNT_W - 1);
                    state_next  = S_MA;
                end
            end
            S_MA: begin
                prod_next   = prod_step;
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                step_next   = step_reg - STEP_W'(1);
                if (step_reg == '0) begin
                    mcand_next  = (PROD_W - 1)'(sum_mag);
                    mplier_next = sum_mag;
                    step_next   = STEP_W'(SUM_W - 1);
                    state_next  = S_MB;
                end
            end
            S_MB: begin
                prod_next   = prod_step;
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                step_next   = step_reg - STEP_W'(1);
                if (step_reg == '0) begin
                    // A negative difference reads as zero.
                    quo_next   = prod_step[PROD_W-1] ? '0
                               : QW'(prod_step[PROD_W-2:0]) << FRACTION_BITS;
                    rem_next   = '0;
                    step_next  = STEP_W'(QW - 1);
                    state_next = S_DV;
                end
            end
            S_DV: begin
                rem_next  = rem_step;
                quo_next  = quo_step;
                step_next = step_reg - STEP_W'(1);
                if (step_reg == '0) begin
                    var_res_next = var_sat;
                    state_next   = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_axis_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = M_TDATA_W'({COUNT_W'(cnt_reg), var_res_reg,
                                               mean_res_reg});
                    m_user_next  = too_few;
                    sum_next     = '0;
                    sumsq_next   = '0;
                    cnt_next     = '0;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            sum_reg     <= '0;
            sumsq_reg   <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sum_reg     <= sum_next;
            sumsq_reg   <= sumsq_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
        prod_reg     <= prod_next;
        mcand_reg    <= mcand_next;
        mplier_reg   <= mplier_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        dvsr_reg     <= dvsr_next;
        step_reg     <= step_next;
        mean_res_reg <= mean_res_next;
        var_res_reg  <= var_res_next;
        m_data_reg   <= m_data_next;
        m_user_reg   <= m_user_next;
    end

    // A frame end always starts the result sequence, which holds off samples.
    a_last_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && s_axis_tlast |=> !s_axis_tready)
        else $error("sample accepted right after a frame end");

    // The included count never runs past the frame limit.
    a_cnt_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_ITEMS))
        else $error("included count beyond MAX_ITEMS");

    // A too-few result carries zero mean and variance.
    a_few_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[MEAN_W+VAR_W-1:0] == '0)
        else $error("too_few result with nonzero mean or variance");

    // Handing over a result leaves the accumulators clear for the next frame.
    a_acc_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DONE && state_next == S_IDLE |=>
            cnt_reg == '0 && sum_reg == '0 && sumsq_reg == '0)
        else $error("accumulators not cleared after a result");

endmodule : masked_mean_variance
`default_nettype wire

// File: test/masked_mean_variance_checker.sv
// ============================================================================
// masked_mean_variance_checker: result predictor and scoreboard
// Follows accepted sample transactions, keeps its own masked count, sum and
// sum of squares, predicts the frame statistics at every tlast and compares
// each accepted result transaction, field by field, with the oldest one.
// ============================================================================
module masked_mean_variance_checker
    import mmv_pkg::*;
#(
    parameter int MAX_ITEMS     = 1048576,
    parameter int SAMPLE_BITS   = 16,
    parameter int FRACTION_BITS = 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_axis_tvalid,
    input  logic                               s_axis_tready,
    // tdata: sample from bit 0, zero padded to bytes.
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]   s_axis_tdata,
    // tuser: include_req.
    input  logic                               s_axis_tuser,
    input  logic                               s_axis_tlast,
    input  logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // tdata: mean_value, variance_value, included_count, zero padding.
    input  logic [M_TDATA_W-1:0]               m_axis_tdata,
    // tuser: too_few.
    input  logic                               m_axis_tuser,
    output int                                 mismatch_count,
    output int                                 pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PRINT_LIMIT = 50;

    typedef struct {
        logic signed [MEAN_W-1:0] mean;
        logic [VAR_W-1:0]         variance;
        logic [COUNT_W-1:0]       count;
        logic                     too_few;
    } frame_stats_t;

    longint                      frame_sum = 0;
    logic [63:0]                 frame_square_sum = '0;
    longint unsigned             frame_count = 0;
    frame_stats_t                expected_stats_q[$];
    frame_stats_t                oldest_stats;
    int                          mismatch_total = 0;
    int                          results_seen = 0;
    int                          stats_pending = 0;

    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic signed [MEAN_W-1:0]      got_mean;
    logic [VAR_W-1:0]              got_variance;
    logic [COUNT_W-1:0]            got_count;

    assign sample_in      = s_axis_tdata[SAMPLE_BITS-1:0];
    assign got_mean       = m_axis_tdata[MEAN_W-1:0];
    assign got_variance   = m_axis_tdata[MEAN_W +: VAR_W];
    assign got_count      = m_axis_tdata[MEAN_W+VAR_W +: COUNT_W];
    assign mismatch_count = mismatch_total;
    assign pending_count  = stats_pending;

    task automatic report_mismatch(input string msg);
        if (mismatch_total < PRINT_LIMIT) begin
            $display("%0t ns: %s", $time, msg);
        end
        mismatch_total++;
    endtask

    // Mean truncates toward zero, the variance is floored, both saturate.
    function automatic frame_stats_t frame_statistics();
        frame_stats_t stats;
        logic [127:0] n;
        logic [127:0] sum_mag;
        logic [127:0] quotient;
        logic [127:0] spread;
        stats.mean     = '0;
        stats.variance = '0;
        stats.count    = frame_count[COUNT_W-1:0];
        stats.too_few  = (frame_count < 2);
        if (!stats.too_few) begin
            n        = 128'(frame_count);
            sum_mag  = 128'((frame_sum < 0) ? -frame_sum : frame_sum);
            quotient = (sum_mag << FRACTION_BITS) / n;
            if (frame_sum < 0) begin
                stats.mean = (quotient > (128'(1) << (MEAN_W - 1))) ? MEAN_MIN
                                                                    : MEAN_W'(-quotient);
            end else begin
                stats.mean = (quotient > 128'(MEAN_MAX)) ? MEAN_MAX : MEAN_W'(quotient);
            end
            spread = n * 128'(frame_square_sum);
            if (spread < sum_mag * sum_mag) begin
                spread = '0;
            end else begin
                spread = spread - sum_mag * sum_mag;
            end
            quotient       = (spread << FRACTION_BITS) / (n * (n - 1));
            stats.variance = (quotient > 128'(VAR_MAX)) ? VAR_MAX : VAR_W'(quotient);
        end
        return stats;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            frame_sum        = 0;
            frame_square_sum = '0;
            frame_count      = 0;
            expected_stats_q.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_stats_q.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with no frame outstanding",
                                              results_seen));
                end else begin
                    oldest_stats = expected_stats_q.pop_front();
                    if (got_mean !== oldest_stats.mean) begin
                        report_mismatch($sformatf("result %0d mean_value: got %0d, expected %0d",
                                                  results_seen, got_mean, oldest_stats.mean));
                    end
                    if (got_variance !== oldest_stats.variance) begin
                        report_mismatch($sformatf(
                            "result %0d variance_value: got %0d, expected %0d",
                            results_seen, got_variance, oldest_stats.variance));
                    end
                    if (got_count !== oldest_stats.count) begin
                        report_mismatch($sformatf(
                            "result %0d included_count: got %0d, expected %0d",
                            results_seen, got_count, oldest_stats.count));
                    end
                    if (m_axis_tuser !== oldest_stats.too_few) begin
                        report_mismatch($sformatf("result %0d too_few: got %b, expected %b",
                                                  results_seen, m_axis_tuser,
                                                  oldest_stats.too_few));
                    end
                end
                results_seen++;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                // Samples past MAX_ITEMS leave the accumulators untouched.
                if (s_axis_tuser && frame_count < MAX_ITEMS) begin
                    frame_sum        = frame_sum + longint'(sample_in);
                    frame_square_sum = frame_square_sum
                                     + 64'(longint'(sample_in) * longint'(sample_in));
                    frame_count      = frame_count + 1;
                end
                if (s_axis_tlast) begin
                    expected_stats_q.push_back(frame_statistics());
                    frame_sum        = 0;
                    frame_square_sum = '0;
                    frame_count      = 0;
                end
            end
        end
        stats_pending = expected_stats_q.size();
    end

endmodule : masked_mean_variance_checker

// File: test/masked_mean_variance_tb.sv
// ============================================================================
// masked_mean_variance_tb: testbench for the masked mean and variance block
// Drives frames of masked samples, lets the checker predict and compare the
// per-frame statistics, and reports the verdict once all results are in.
// ============================================================================
module masked_mean_variance_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mmv_pkg::*;

    localparam int CLK_PERIOD    = 20;
    localparam int RESET_CYCLES  = 5;
    localparam int MAX_ITEMS     = 1048576;
    localparam int SAMPLE_BITS   = 16;
    localparam int FRACTION_BITS = 8;
    localparam int S_TDATA_W     = ((SAMPLE_BITS + 7) / 8) * 8;

    // Sample transactions per random phase.
    localparam int PHASE_ITEMS   = 145;
    localparam int NUM_PHASES    = 4;
    // Longest hold-off of the sample side after each tlast, without output stalls.
    localparam int RESULT_LATENCY = 243;
    localparam int DRAIN_CYCLES   = 2 * RESULT_LATENCY;
    // Generous run limit: about 600 samples stay well within it, even if each
    // closed a full frame with the heaviest idling.
    localparam int CYCLE_LIMIT   = 1_000_000;

    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN =
        SAMPLE_BITS'(-(1 <<< (SAMPLE_BITS - 1)));
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX =
        SAMPLE_BITS'((1 <<< (SAMPLE_BITS - 1)) - 1);

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  s_axis_tlast = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic                  m_axis_tuser;

    int                    mismatch_count;
    int                    pending_count;
    int                    cycle_count = 0;

    // Idle and stall odds in percent, changed from phase to phase.
    int                    send_idle_pct = 0;
    int                    recv_stall_pct = 0;

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    masked_mean_variance #(
        .MAX_ITEMS     (MAX_ITEMS),
        .SAMPLE_BITS   (SAMPLE_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    masked_mean_variance_checker #(
        .MAX_ITEMS     (MAX_ITEMS),
        .SAMPLE_BITS   (SAMPLE_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .s_axis_tlast   (s_axis_tlast),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    // The result receiver decides its tready afresh at every falling edge,
    // so stalls land on every phase of the block's work.
    always @(negedge aclk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // Watchdog: a hung handshake ends the run here.
    initial begin
        wait (cycle_count == CYCLE_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    // Offers one sample transaction and returns at the falling edge after it
    // was accepted. Entered at a falling edge. tvalid stays high on return, so
    // a following call keeps it high and back-to-back transactions get through
    // with a single assignment per edge. Idle cycles carry random junk that
    // the block must ignore.
    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] value,
                               input logic include_req, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= S_TDATA_W'($urandom);
            s_axis_tuser  <= 1'($urandom);
            s_axis_tlast  <= 1'($urandom);
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= S_TDATA_W'(value);
        s_axis_tuser  <= include_req;
        s_axis_tlast  <= last;
        do begin
            @(posedge aclk);
        end while (!s_axis_tready);
        @(negedge aclk);
    endtask

    // Random frames until the budget of sample transactions is spent. The
    // frame under way is always finished. Most frames are short so many
    // results come back; a few are long, a few have no or almost no included
    // samples.
    task automatic run_random_frames(input int item_budget);
        int                            counted;
        int                            frame_len;
        int                            include_pct;
        logic                          include_req;
        logic                          last;
        logic signed [SAMPLE_BITS-1:0] value;
        counted = 0;
        while (counted < item_budget) begin
            case ($urandom_range(9))
                0: begin
                    frame_len = $urandom_range(1, 2);
                end
                1: begin
                    frame_len = $urandom_range(13, 40);
                end
                default: begin
                    frame_len = $urandom_range(3, 12);
                end
            endcase
            case ($urandom_range(7))
                0: begin
                    include_pct = 0;
                end
                1: begin
                    include_pct = 15;
                end
                2: begin
                    include_pct = 100;
                end
                default: begin
                    include_pct = 75;
                end
            endcase
            for (int i = 0; i < frame_len; i++) begin
                // Full-scale values show up often, small ones now and then.
                case ($urandom_range(9))
                    0: begin
                        value = SAMPLE_MIN;
                    end
                    1: begin
                        value = SAMPLE_MAX;
                    end
                    2: begin
                        value = SAMPLE_BITS'(int'($urandom_range(4)) - 2);
                    end
                    default: begin
                        value = SAMPLE_BITS'($urandom);
                    end
                endcase
                include_req = ($urandom_range(99) < include_pct);
                last        = (i == frame_len - 1);
                send_sample(value, include_req, last);
                counted++;
            end
        end
    endtask

    initial begin
        // Synchronous reset, held for RESET_CYCLES clocks and released at a falling
        // edge, so the block leaves reset before the first sample transaction.
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed frames, no idling on either side.
        // An empty frame: nothing included, so the count is zero and too_few.
        send_sample(16'sd0, 1'b0, 1'b1);
        // A single included sample is still too few.
        send_sample(-16'sd5, 1'b1, 1'b1);
        // Highest positive mean, zero variance.
        send_sample(SAMPLE_MAX, 1'b1, 1'b0);
        send_sample(SAMPLE_MAX, 1'b1, 1'b1);
        // Most negative mean.
        send_sample(SAMPLE_MIN, 1'b1, 1'b0);
        send_sample(SAMPLE_MIN, 1'b1, 1'b1);
        // Opposite full-scale samples give the largest two-sample spread.
        send_sample(SAMPLE_MAX, 1'b1, 1'b0);
        send_sample(SAMPLE_MIN, 1'b1, 1'b1);
        // A negative mean with a fraction that must be cut toward zero.
        send_sample(-16'sd1, 1'b1, 1'b0);
        send_sample(-16'sd2, 1'b1, 1'b0);
        send_sample(-16'sd2, 1'b1, 1'b1);
        // The positive counterpart, with an excluded sample in the middle.
        send_sample(16'sd1, 1'b1, 1'b0);
        send_sample(16'sd2, 1'b1, 1'b0);
        send_sample(16'sd1234, 1'b0, 1'b0);
        send_sample(16'sd2, 1'b1, 1'b1);
        // The frame closes on an excluded sample, which must not count.
        send_sample(16'sd100, 1'b1, 1'b0);
        send_sample(-16'sd100, 1'b1, 1'b0);
        send_sample(16'sd7, 1'b0, 1'b1);
        // All zeros.
        send_sample(16'sd0, 1'b1, 1'b0);
        send_sample(16'sd0, 1'b1, 1'b1);

        // Random phases: no idling, sender idle, receiver stalling, both.
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 45;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 45;
                end
                default: begin
                    send_idle_pct  = 22;
                    recv_stall_pct = 22;
                end
            endcase
            run_random_frames(PHASE_ITEMS);
        end
        s_axis_tvalid <= 1'b0;

        // Wait for every outstanding result, then give the block time to show
        // any stray transaction.
        while (pending_count != 0) begin
            @(negedge aclk);
        end
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (mismatch_count == 0 && pending_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule : masked_mean_variance_tb
